/* hw/rtl/fltw_pkg.sv */
// ----------------------------------------------------------------------------
// fltw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package fltw_pkg;

	localparam int TablePagesDef  = 64;
	localparam int EntriesPerTbl  = 512;
	localparam int FrameBitsDef   = 40;
	localparam int IdxBits        = 9;
	localparam int PageShift      = 12;
	localparam int VaBits         = 48;
	localparam int PaBits         = 52;
	localparam int EntBits        = 45;

	localparam logic [2:0] OP_MAP   = 3'd0;
	localparam logic [2:0] OP_XLATE = 3'd1;
	localparam logic [2:0] OP_SET   = 3'd2;
	localparam logic [2:0] OP_GET   = 3'd3;
	localparam logic [2:0] OP_OR    = 3'd4;
	localparam logic [2:0] OP_CLR   = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNALIGNED = 2'd1;
	localparam logic [1:0] ST_UNMAPPED  = 2'd2;
	localparam logic [1:0] ST_NOPAGES   = 2'd3;

	// datapath commands from controller
	typedef struct packed {
		logic       load;      // capture request
		logic       rd;        // read entry at page_q, level index
		logic [1:0] lvl;       // level for index select
		logic       wr_dir;    // write new directory entry for alloc page
		logic       wr_leaf;   // write leaf per opcode
		logic       wr_clr;    // clear one entry of alloc page
		logic       alloc;     // take next free page
		logic       adv;       // follow read entry to next page
		logic       adv_new;   // follow freshly allocated page
		logic       rslt;      // build result from entry (ok or unaligned)
		logic       fail;      // build error result
		logic [1:0] fail_st;
	} fltw_cmd_t;

	// datapath status to controller
	typedef struct packed {
		logic [2:0] op;
		logic       present;   // read entry present
		logic       in_range;  // read entry frame < table pages
		logic       pages_ok;  // allocator not exhausted
		logic       clr_last;  // clear sweep at final entry
	} fltw_sts_t;

endpackage

/* hw/rtl/fltw_if.sv */
// ----------------------------------------------------------------------------
// fltw_req_if / fltw_rsp_if
// Valid/ready channels for walker requests and results.
// ----------------------------------------------------------------------------
interface fltw_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [47:0] virt_addr;
	logic [51:0] phys_addr;
	logic [3:0]  perm_bits;
	modport source (output valid, opcode, virt_addr, phys_addr, perm_bits, input ready);
	modport sink   (input valid, opcode, virt_addr, phys_addr, perm_bits, output ready);
endinterface

interface fltw_rsp_if;
	logic        valid;
	logic        ready;
	logic [51:0] phys_result;
	logic [3:0]  perm_result;
	logic [1:0]  status;
	modport source (output valid, phys_result, perm_result, status, input ready);
	modport sink   (input valid, phys_result, perm_result, status, output ready);
endinterface

/* hw/rtl/fltw_ctrl.sv */
// ----------------------------------------------------------------------------
// fltw_ctrl
// Sequencer for walks, allocation sweeps, and table store clearing.
// ----------------------------------------------------------------------------
module fltw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  fltw_pkg::fltw_sts_t  sts,
	output fltw_pkg::fltw_cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RD, S_WAIT, S_EVAL, S_CLR, S_LEAF, S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] lvl_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		cmd = '0;
		cmd.lvl = lvl_q;
		case (state_q)
			S_INIT: cmd.wr_clr = 1'b1;
			S_IDLE: cmd.load = in_valid;
			S_RD:   cmd.rd = 1'b1;
			S_EVAL: begin
				if (lvl_q == 2'd3) begin
					if (!sts.present && sts.op != fltw_pkg::OP_MAP) begin
						cmd.fail = 1'b1;
						cmd.fail_st = fltw_pkg::ST_UNMAPPED;
					end else begin
						cmd.wr_leaf = 1'b1;
						cmd.rslt = 1'b1;
					end
				end else if (sts.op == fltw_pkg::OP_MAP) begin
					if (sts.present) cmd.adv = 1'b1;
					else if (!sts.pages_ok) begin
						cmd.fail = 1'b1;
						cmd.fail_st = fltw_pkg::ST_NOPAGES;
					end else begin
						cmd.alloc = 1'b1;
						cmd.wr_dir = 1'b1;
					end
				end else if (sts.present && sts.in_range) cmd.adv = 1'b1;
				else begin
					cmd.fail = 1'b1;
					cmd.fail_st = fltw_pkg::ST_UNMAPPED;
				end
			end
			S_CLR: begin
				cmd.wr_clr = 1'b1;
				cmd.adv_new = sts.clr_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			lvl_q   <= '0;
		end else begin
			case (state_q)
				S_INIT: if (sts.clr_last) begin
					state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					lvl_q <= '0;
					state_q <= (sts.op > fltw_pkg::OP_CLR) ? S_DONE : S_RD;
				end
				S_RD:   state_q <= S_WAIT;
				S_WAIT: state_q <= S_EVAL;
				S_EVAL: begin
					if (cmd.fail || cmd.rslt) state_q <= S_DONE;
					else if (cmd.alloc) state_q <= S_CLR;
					else begin
						lvl_q <= lvl_q + 2'd1;
						state_q <= S_RD;
					end
				end
				S_CLR: if (sts.clr_last) begin
					lvl_q <= lvl_q + 2'd1;
					state_q <= S_RD;
				end
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/fltw_dp.sv */
// ----------------------------------------------------------------------------
// fltw_dp
// Request registers, table store, allocator, and result registers.
// ----------------------------------------------------------------------------
module fltw_dp #(
	parameter int TABLE_PAGES = fltw_pkg::TablePagesDef,
	parameter int FRAME_BITS  = fltw_pkg::FrameBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fltw_pkg::fltw_cmd_t  cmd,
	output fltw_pkg::fltw_sts_t  sts,
	input  logic [2:0]           opcode,
	input  logic [47:0]          virt_addr,
	input  logic [51:0]          phys_addr,
	input  logic [3:0]           perm_bits,
	output logic [51:0]          phys_result,
	output logic [3:0]           perm_result,
	output logic [1:0]           status
);
	localparam int PgBits = $clog2(TABLE_PAGES);
	localparam int AdBits = PgBits + fltw_pkg::IdxBits;
	localparam int Depth  = TABLE_PAGES * fltw_pkg::EntriesPerTbl;

	logic [fltw_pkg::EntBits-1:0] mem [Depth];

	logic [2:0]  op_q;
	logic [47:0] va_q;
	logic [FRAME_BITS-1:0] fr_q;
	logic [3:0]  pb_q;
	logic        unal_q;
	logic [PgBits-1:0] page_q, newp_q;
	logic [PgBits:0]   free_q;
	logic [fltw_pkg::IdxBits-1:0] clr_q;
	logic [fltw_pkg::EntBits-1:0] rd_q;
	logic [AdBits-1:0] addr;
	logic [fltw_pkg::IdxBits-1:0] idx;
	logic [39:0] efr;
	logic [3:0]  perm_old, perm_new;
	logic [fltw_pkg::EntBits-1:0] leaf_e;
	logic        we;
	logic [AdBits-1:0] wa;
	logic [fltw_pkg::EntBits-1:0] wd;

	always_comb begin
		case (cmd.lvl)
			2'd0: idx = va_q[47:39];
			2'd1: idx = va_q[38:30];
			2'd2: idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end
	assign addr = {page_q, idx};

	assign efr      = rd_q[44:5];
	assign perm_old = rd_q[4:1];
	always_comb begin
		case (op_q)
			fltw_pkg::OP_SET: perm_new = pb_q;
			fltw_pkg::OP_OR:  perm_new = perm_old | pb_q;
			fltw_pkg::OP_CLR: perm_new = perm_old & ~pb_q;
			default:          perm_new = perm_old;
		endcase
		if (op_q == fltw_pkg::OP_MAP)
			leaf_e = {(40)'(fr_q), perm_old[3:1], 2'b11};
		else
			leaf_e = {efr, perm_new, rd_q[0]};
	end

	// single write port
	always_comb begin
		we = 1'b0;
		wa = addr;
		wd = leaf_e;
		if (cmd.wr_clr) begin
			we = 1'b1;
			wa = {newp_q, clr_q};
			wd = '0;
		end else if (cmd.wr_dir) begin
			we = 1'b1;
			wd = {(40)'(free_q[PgBits-1:0]), 3'b000, 2'b11};
		end else if (cmd.wr_leaf) begin
			we = (op_q != fltw_pkg::OP_XLATE) && (op_q != fltw_pkg::OP_GET);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (cmd.rd) rd_q <= mem[addr];
	end

	assign sts.op       = cmd.load ? opcode : op_q;
	assign sts.present  = rd_q[0];
	assign sts.in_range = (efr < 40'(TABLE_PAGES));
	assign sts.pages_ok = (free_q < (PgBits+1)'(TABLE_PAGES));
	assign sts.clr_last = (clr_q == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= (PgBits+1)'(1);
			clr_q  <= '0;
			newp_q <= '0;
			page_q <= '0;
		end else begin
			if (cmd.wr_clr) clr_q <= clr_q + 1'b1;
			if (cmd.load) page_q <= '0;
			if (cmd.alloc) begin
				newp_q <= free_q[PgBits-1:0];
				free_q <= free_q + 1'b1;
			end
			if (cmd.adv) page_q <= efr[PgBits-1:0];
			if (cmd.adv_new) page_q <= newp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			va_q   <= virt_addr;
			fr_q   <= phys_addr[fltw_pkg::PageShift +: FRAME_BITS];
			pb_q   <= perm_bits;
			unal_q <= (opcode == fltw_pkg::OP_MAP) &&
				((virt_addr[11:0] | phys_addr[11:0]) != 12'd0);
			phys_result <= '0;
			perm_result <= '0;
			status      <= fltw_pkg::ST_OK;
		end
		if (cmd.fail) begin
			phys_result <= '0;
			perm_result <= '0;
			status      <= cmd.fail_st;
		end
		if (cmd.rslt) begin
			phys_result <= {leaf_e[44:5], va_q[11:0]};
			perm_result <= leaf_e[4:1];
			status      <= unal_q ? fltw_pkg::ST_UNALIGNED : fltw_pkg::ST_OK;
		end
	end
endmodule

/* hw/rtl/four_level_page_table_walker.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page table walker with internal table store and bump allocator.
// ----------------------------------------------------------------------------
// Each item with a defined opcode takes one walk; a lookup item passes through
// read issue (S_RD), registered read (S_WAIT) and evaluate (S_EVAL) at each
// level, then the result state (S_DONE). A map that creates a level adds a
// clearing sweep over all 512 entries of the new table page. After reset the
// root page is cleared in a pass during which no item is accepted. One result
// per item, held in an output register until taken.
module four_level_page_table_walker #(
	parameter int TABLE_PAGES = fltw_pkg::TablePagesDef,
	parameter int FRAME_BITS  = fltw_pkg::FrameBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	fltw_req_if.sink    req,
	fltw_rsp_if.source  rsp
);
	fltw_pkg::fltw_cmd_t cmd;
	fltw_pkg::fltw_sts_t sts;

	// controller: handshakes and step sequencing
	fltw_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts, .cmd
	);

	// datapath: table store, allocator, result registers
	fltw_dp #(.TABLE_PAGES(TABLE_PAGES), .FRAME_BITS(FRAME_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.opcode(req.opcode), .virt_addr(req.virt_addr),
		.phys_addr(req.phys_addr), .perm_bits(req.perm_bits),
		.phys_result(rsp.phys_result), .perm_result(rsp.perm_result),
		.status(rsp.status)
	);
endmodule

/* verif/four_level_page_table_walker_tb.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker_tb
// Drives random and directed map / translate / permission items into the
// walker and checks every result against a behavioral page table kept in the
// testbench, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class walk_scoreboard;
	// behavioral copy of the table store, keyed by page*512 + index
	logic [44:0] entries [int];
	int next_table;
	logic [51:0] exp_phys [$];
	logic [3:0]  exp_perm [$];
	logic [1:0]  exp_stat [$];
	int errors;

	function new();
		next_table = 1;
		errors = 0;
	endfunction

	function logic [44:0] rd(int page, int idx);
		if (page >= fltw_pkg::TablePagesDef || !entries.exists(page * 512 + idx))
			return '0;
		return entries[page * 512 + idx];
	endfunction

	function void wr(int page, int idx, logic [44:0] e);
		if (page < fltw_pkg::TablePagesDef)
			entries[page * 512 + idx] = e;
	endfunction

	// compute the expected result of one accepted item and queue it
	function void note_request(logic [2:0] op, logic [47:0] va, logic [51:0] pa,
			logic [3:0] pb);
		int page, idx, lv;
		logic [44:0] e;
		logic [3:0] perms;
		logic [1:0] st;
		bit fail;
		st = fltw_pkg::ST_OK;
		fail = 0;
		page = 0;
		if (op > fltw_pkg::OP_CLR) begin
			push(0, 0, fltw_pkg::ST_OK);
			return;
		end
		if (op == fltw_pkg::OP_MAP) begin
			if ((va[11:0] | pa[11:0]) != 0)
				st = fltw_pkg::ST_UNALIGNED;
			for (lv = 0; lv < 3; lv++) begin
				idx = (va >> (39 - 9 * lv)) & 'h1ff;
				e = rd(page, idx);
				if (!e[0]) begin
					if (next_table >= fltw_pkg::TablePagesDef) begin
						push(0, 0, fltw_pkg::ST_NOPAGES);
						return;
					end
					for (int i = 0; i < 512; i++)
						entries.delete(next_table * 512 + i);
					e = (45'(next_table) << 5) | 45'd3;
					next_table++;
					wr(page, idx, e);
				end
				page = int'(e[44:5]);
			end
			idx = va[20:12];
			e = rd(page, idx);
			e = (e & 45'h1c) | 45'd3 | {pa[51:12], 5'd0};
			wr(page, idx, e);
		end else begin
			for (lv = 0; lv < 3 && !fail; lv++) begin
				idx = (va >> (39 - 9 * lv)) & 'h1ff;
				e = rd(page, idx);
				if (!e[0] || e[44:5] >= fltw_pkg::TablePagesDef)
					fail = 1;
				else
					page = int'(e[44:5]);
			end
			if (!fail) begin
				e = rd(page, va[20:12]);
				fail = !e[0];
			end
			if (fail) begin
				push(0, 0, fltw_pkg::ST_UNMAPPED);
				return;
			end
			if (op != fltw_pkg::OP_XLATE && op != fltw_pkg::OP_GET) begin
				perms = e[4:1];
				if (op == fltw_pkg::OP_SET)
					perms = pb;
				else if (op == fltw_pkg::OP_OR)
					perms = perms | pb;
				else
					perms = perms & ~pb;
				e[4:1] = perms;
				wr(page, va[20:12], e);
			end
		end
		push({e[44:5], va[11:0]}, e[4:1], st);
	endfunction

	function void push(logic [51:0] p, logic [3:0] m, logic [1:0] s);
		exp_phys.push_back(p);
		exp_perm.push_back(m);
		exp_stat.push_back(s);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task check_result(logic [51:0] p, logic [3:0] m, logic [1:0] s);
		logic [51:0] ep;
		logic [3:0] em;
		logic [1:0] es;
		if (exp_stat.size() == 0) begin
			report("unexpected result", 64'(p), 64'd0);
			return;
		end
		ep = exp_phys.pop_front();
		em = exp_perm.pop_front();
		es = exp_stat.pop_front();
		if (s !== es) report("status", 64'(s), 64'(es));
		if (p !== ep) report("phys_result", 64'(p), 64'(ep));
		if (m !== em) report("perm_result", 64'(m), 64'(em));
	endtask

	function int pending();
		return exp_stat.size();
	endfunction
endclass

module four_level_page_table_walker_tb;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	fltw_req_if req ();
	fltw_rsp_if rsp ();

	four_level_page_table_walker uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	walk_scoreboard sb = new();

	int send_idle;      // percent of cycles the sender holds back
	int recv_stall;     // percent of cycles the receiver stalls
	bit hold_off;       // long receiver hold-off in progress
	int quiet_cycles;

	// a small pool of mapped pages so lookups mostly hit
	logic [47:0] va_pool [$];

	initial begin
		req.valid = 0;
		req.opcode = '0;
		req.virt_addr = '0;
		req.phys_addr = '0;
		req.perm_bits = '0;
		rsp.ready = 0;
	end

	// receiver: random stalls, or a long hold-off while the sender keeps going
	always @(posedge clk) begin
		if (hold_off)
			rsp.ready <= 0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_stall);
	end

	// result checking at the edge where an item is taken
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.phys_result, rsp.perm_result, rsp.status);
	end

	// watchdog: count cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// offer one item; valid stays high until accepted and drops when idling
	task automatic send_item(logic [2:0] op, logic [47:0] va, logic [51:0] pa,
			logic [3:0] pb);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.opcode <= op;
		req.virt_addr <= va;
		req.phys_addr <= pa;
		req.perm_bits <= pb;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_request(op, va, pa, pb);
	endtask

	function automatic logic [47:0] pick_va();
		logic [47:0] va;
		if (va_pool.size() != 0 && $urandom_range(99) < 80) begin
			va = va_pool[$urandom_range(va_pool.size() - 1)];
			va[11:0] = 12'($urandom_range(4095));
			// neighbor page in the same leaf table now and then
			if ($urandom_range(3) == 0)
				va[20:12] = 9'($urandom_range(511));
			return va;
		end
		va = 48'({$urandom(), $urandom()});
		return va;
	endfunction

	task automatic random_item();
		logic [2:0] op;
		logic [47:0] va;
		logic [51:0] pa;
		op = $urandom_range(9) < 3 ? fltw_pkg::OP_MAP : 3'($urandom_range(1, 7));
		if ($urandom_range(19) == 0)
			op = 3'($urandom_range(6, 7));
		else if (op > fltw_pkg::OP_CLR)
			op = 3'($urandom_range(fltw_pkg::OP_XLATE, fltw_pkg::OP_CLR));
		va = pick_va();
		pa = 52'({$urandom(), $urandom()});
		if (op == fltw_pkg::OP_MAP) begin
			if ($urandom_range(3) != 0) begin
				va[11:0] = 0;
				pa[11:0] = 0;
			end
			if (va_pool.size() < 40)
				va_pool.push_back(va);
		end
		send_item(op, va, pa, 4'($urandom_range(15)));
	endtask

	task automatic drain();
		req.valid <= 0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		send_idle = 0;
		recv_stall = 0;
		hold_off = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: misses on the empty tree, field extremes, every opcode
		send_item(fltw_pkg::OP_XLATE, '0, '0, 4'h0);
		send_item(fltw_pkg::OP_GET, '1, '0, 4'hf);
		send_item(fltw_pkg::OP_MAP, '0, '0, 4'h0);
		send_item(fltw_pkg::OP_XLATE, 48'h0000_0000_0abc, '0, 4'h0);
		send_item(fltw_pkg::OP_MAP, '1, '1, 4'hf);             // unaligned both sides
		send_item(fltw_pkg::OP_XLATE, '1, '0, 4'h0);
		send_item(fltw_pkg::OP_SET, '1, '0, 4'hf);
		send_item(fltw_pkg::OP_CLR, '1, '0, 4'h5);
		send_item(fltw_pkg::OP_OR, '1, '0, 4'h2);
		send_item(fltw_pkg::OP_GET, '1, '0, 4'h0);
		// remap keeps the upper three perm bits and sets the lowest
		send_item(fltw_pkg::OP_MAP, 48'hffff_ffff_f000, 52'h0000_0000_0f000, 4'h0);
		send_item(fltw_pkg::OP_GET, 48'hffff_ffff_f000, '0, 4'h0);
		send_item(fltw_pkg::OP_MAP, 48'h0000_0000_0000, 52'h0000_0000_00123, 4'h0);
		send_item(fltw_pkg::OP_XLATE, 48'h0000_0000_1000, '0, 4'h0); // leaf not present
		send_item(fltw_pkg::OP_SET, 48'h8000_0000_0000, '0, 4'hf);    // top level missing
		send_item(3'd6, 48'h1234_5678_9abc, '1, 4'hf);
		send_item(3'd7, '0, '0, 4'h0);
		send_item(fltw_pkg::OP_MAP, 48'h5555_5555_5000, 52'haaaa_aaaa_aa000, 4'ha);
		send_item(fltw_pkg::OP_XLATE, 48'h5555_5555_5fff, '0, 4'h0);
		drain();

		// random phases with differing idle patterns
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 77; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 77; end
				default: begin send_idle = 9; recv_stall = 9; end
			endcase
			if (ph == 0) begin
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
					repeat (20) random_item();
				join
			end
			repeat (240) random_item();
			drain();
		end

		// allocator likely exhausted by now; exercise its edge with fresh maps
		send_idle = 0;
		recv_stall = 0;
		repeat (20)
			send_item(fltw_pkg::OP_MAP, {$urandom(), 16'h0} << 12, '0, 4'h0);
		drain();
		repeat (600) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
